@@ sv/crt_pkg.sv @@
// ----------------------------------------------------------------------------
// crt_pkg
// Types, codes and field widths shared by the checkpoint/reset tracker files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package crt_pkg;

  localparam int unsigned MAX_OPERATORS = 32;

  localparam int unsigned CNT_W   = 6;
  localparam int unsigned SEQ_W   = 48;
  localparam int unsigned EPOCH_W = SEQ_W + 1;
  localparam int unsigned TRY_W   = 31;
  localparam int unsigned OP_W    = $clog2(MAX_OPERATORS);
  localparam int unsigned MASK_W  = MAX_OPERATORS;
  localparam int unsigned REG_W   = 16;
  localparam int unsigned NB_W    = $clog2(MAX_OPERATORS + 1);

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_OPERATORS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NONBLOCKING_MASK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_INDEX     = 2'd2;

  // Stream widths
  localparam int unsigned IN_TUSER_W  = 3;
  localparam int unsigned IN_TDATA_W  = 88;
  localparam int unsigned OUT_TDATA_W = 152;

  // Request kinds
  localparam logic [2:0] REQ_DRAIN_DONE  = 3'd0;
  localparam logic [2:0] REQ_CKPT_DONE   = 3'd1;
  localparam logic [2:0] REQ_RESET_DONE  = 3'd2;
  localparam logic [2:0] REQ_CKPT_QUERY  = 3'd3;
  localparam logic [2:0] REQ_RESET_QUERY = 3'd4;

  // Notification codes
  localparam logic [1:0] NOTIFY_NONE       = 2'd0;
  localparam logic [1:0] NOTIFY_BLOCKING   = 2'd1;
  localparam logic [1:0] NOTIFY_CKPT_DONE  = 2'd2;
  localparam logic [1:0] NOTIFY_RESET_DONE = 2'd3;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef struct packed {
    logic [2:0]       req_type;
    logic [SEQ_W-1:0] seq_id;
    logic [OP_W-1:0]  op_index;
    logic [TRY_W-1:0] reset_attempt;
  } crt_item_t;

  typedef struct packed {
    logic [CNT_W-1:0]  num_operators;
    logic [MASK_W-1:0] nonblocking_mask;
    logic [NB_W-1:0]   nb_count;
    logic [REG_W-1:0]  region_index;
  } crt_cfg_t;

  typedef struct packed {
    logic [1:0]                notify;
    logic                      proceed;
    logic [SEQ_W-1:0]          checkpoint_epoch;
    logic signed [EPOCH_W-1:0] reset_epoch;
    logic [TRY_W-1:0]          reset_try;
    logic [REG_W-1:0]          region_out;
  } crt_result_t;

  typedef struct packed {
    logic                      resetting;
    logic                      blocking_notified;
    logic [SEQ_W-1:0]          latest_checkpoint;
    logic signed [EPOCH_W-1:0] latest_reset;
    logic [TRY_W-1:0]          latest_attempt;
    logic [CNT_W-1:0]          drain_count;
    logic [CNT_W-1:0]          blocking_count;
    logic [CNT_W-1:0]          nonblocking_count;
    logic [CNT_W-1:0]          reset_count;
  } crt_state_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (c == CNT_MAX) ? CNT_MAX : c + 1'b1;
  endfunction

endpackage

`default_nettype wire

@@ sv/crt_cfg.sv @@
// ----------------------------------------------------------------------------
// crt_cfg
// Configuration registers and the registered count of non-blocking operators.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module crt_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [crt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [crt_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output crt_pkg::crt_cfg_t                   cfg
);
  import crt_pkg::*;

  logic [CNT_W-1:0]  num_operators;
  logic [MASK_W-1:0] nonblocking_mask;
  logic [REG_W-1:0]  region_index;
  logic [NB_W-1:0]   nb_count;
  logic [NB_W-1:0]   nb_count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_operators    <= CNT_W'(1);
      nonblocking_mask <= '0;
      region_index     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NUM_OPERATORS:    num_operators    <= cfg_wdata[CNT_W-1:0];
        CFG_NONBLOCKING_MASK: nonblocking_mask <= cfg_wdata[MASK_W-1:0];
        CFG_REGION_INDEX:     region_index     <= cfg_wdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  // Population count of the mask, registered as nb_count after a mask write.
  always_comb begin
    nb_count_next = '0;
    for (int i = 0; i < MASK_W; i++) begin
      nb_count_next = nb_count_next + NB_W'(nonblocking_mask[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nb_count <= '0;
    end else begin
      nb_count <= nb_count_next;
    end
  end

  assign cfg.num_operators    = num_operators;
  assign cfg.nonblocking_mask = nonblocking_mask;
  assign cfg.nb_count         = nb_count;
  assign cfg.region_index     = region_index;

endmodule

`default_nettype wire

@@ sv/crt_engine.sv @@
// ----------------------------------------------------------------------------
// crt_engine
// Epoch state registers and the single-pass update for one item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module crt_engine (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               fire,
  input  wire crt_pkg::crt_item_t item,
  input  wire crt_pkg::crt_cfg_t  cfg,
  output crt_pkg::crt_result_t    result
);
  import crt_pkg::*;

  crt_state_t state;
  crt_state_t state_next;
  crt_state_t upd;
  logic [1:0] notify;
  logic       proceed;
  logic       nb_op;
  logic       seq_gt;
  logic       seq_eq;
  logic signed [EPOCH_W-1:0] sseq;
  logic       counted;
  logic [CNT_W:0] bn_sum;
  logic [CNT_W-1:0] n_ops;
  logic [CNT_W-1:0] nb6;
  logic       nb_fits;

  assign n_ops   = cfg.num_operators;
  assign nb6     = CNT_W'(cfg.nb_count);
  assign nb_fits = ({1'b0, cfg.nb_count} <= (NB_W + 1)'(n_ops));
  assign nb_op   = cfg.nonblocking_mask[item.op_index];
  assign seq_gt  = item.seq_id > state.latest_checkpoint;
  assign seq_eq  = item.seq_id == state.latest_checkpoint;
  assign sseq    = $signed({1'b0, item.seq_id});

  always_comb begin
    upd     = state;
    notify  = NOTIFY_NONE;
    proceed = 1'b0;
    counted = 1'b0;
    bn_sum  = '0;
    case (item.req_type)
      REQ_DRAIN_DONE, REQ_CKPT_DONE: begin
        if (seq_gt) begin
          upd.latest_checkpoint = item.seq_id;
          upd.drain_count       = (item.req_type == REQ_DRAIN_DONE) ? CNT_W'(1) : '0;
          upd.blocking_count    = (item.req_type == REQ_CKPT_DONE && !nb_op) ?
                                  CNT_W'(1) : '0;
          upd.nonblocking_count = (item.req_type == REQ_CKPT_DONE && nb_op) ?
                                  CNT_W'(1) : '0;
        end else if (seq_eq) begin
          if (item.req_type == REQ_DRAIN_DONE) begin
            upd.drain_count = sat_inc(state.drain_count);
          end else if (nb_op) begin
            upd.nonblocking_count = sat_inc(state.nonblocking_count);
          end else begin
            upd.blocking_count = sat_inc(state.blocking_count);
          end
        end
        // Completion check on the updated counters
        if ((seq_gt || seq_eq) && upd.drain_count == n_ops) begin
          bn_sum = {1'b0, upd.blocking_count} + {1'b0, upd.nonblocking_count};
          if (cfg.nb_count != '0) begin
            if (bn_sum == {1'b0, n_ops}) begin
              notify = NOTIFY_CKPT_DONE;
            end else if (nb_fits && upd.blocking_count == n_ops - nb6 &&
                         !upd.blocking_notified) begin
              notify = NOTIFY_BLOCKING;
              upd.blocking_notified = 1'b1;
            end
          end else if (upd.blocking_count == n_ops) begin
            notify = NOTIFY_CKPT_DONE;
          end
        end
      end
      REQ_RESET_DONE: begin
        upd.resetting = 1'b1;
        if (sseq > state.latest_reset) begin
          counted             = 1'b1;
          upd.latest_reset    = sseq;
          upd.latest_attempt  = item.reset_attempt;
          upd.reset_count     = CNT_W'(1);
        end else if (sseq == state.latest_reset) begin
          if (item.reset_attempt == state.latest_attempt) begin
            counted         = 1'b1;
            upd.reset_count = sat_inc(state.reset_count);
          end else if (item.reset_attempt > state.latest_attempt) begin
            counted            = 1'b1;
            upd.latest_attempt = item.reset_attempt;
            upd.reset_count    = CNT_W'(1);
          end
        end
        if (counted && upd.reset_count == n_ops) begin
          notify        = NOTIFY_RESET_DONE;
          upd.resetting = 1'b0;
        end
      end
      REQ_CKPT_QUERY: begin
        proceed = !state.resetting && (seq_gt || seq_eq);
      end
      REQ_RESET_QUERY: begin
        proceed = !((sseq < state.latest_reset) ||
                    (sseq == state.latest_reset &&
                     item.reset_attempt < state.latest_attempt));
      end
      default: ;
    endcase

    // A completed checkpoint or reset clears every counter and the flag.
    state_next = upd;
    if (notify == NOTIFY_CKPT_DONE || notify == NOTIFY_RESET_DONE) begin
      state_next.drain_count       = '0;
      state_next.blocking_count    = '0;
      state_next.nonblocking_count = '0;
      state_next.reset_count       = '0;
      state_next.blocking_notified = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.resetting         <= 1'b0;
      state.blocking_notified <= 1'b0;
      state.latest_checkpoint <= '0;
      state.latest_reset      <= '1;
      state.latest_attempt    <= '0;
      state.drain_count       <= '0;
      state.blocking_count    <= '0;
      state.nonblocking_count <= '0;
      state.reset_count       <= '0;
    end else if (fire) begin
      state <= state_next;
    end
  end

  assign result.notify           = notify;
  assign result.proceed          = proceed;
  assign result.checkpoint_epoch = state_next.latest_checkpoint;
  assign result.reset_epoch      = state_next.latest_reset;
  assign result.reset_try        = state_next.latest_attempt;
  assign result.region_out       = cfg.region_index;

endmodule

`default_nettype wire

@@ sv/checkpoint_reset_completion_tracker_core.sv @@
// ----------------------------------------------------------------------------
// checkpoint_reset_completion_tracker_core
// Checkpoint and reset epoch completion tracker for one region of operators.
// ----------------------------------------------------------------------------
// Each item on the slave stream is a drain-done, checkpoint-done or
// reset-done event, or a checkpoint or reset proceed query, and yields exactly
// one item on the master stream carrying the notification code, the proceed
// verdict and the latest checkpoint epoch, reset epoch and reset attempt after
// that item, plus the configured region index. The block takes one item per
// clock while the master side does not stall: an item is held in the input
// register, the epoch update runs in a single combinational pass into the
// result register, and the item shows up on the master side once that
// register is loaded. While a result waits to be taken the slave side
// accepts one more item into the input register and then stalls. Write
// configuration only while no item is in flight; a mask write reaches the
// non-blocking operator count through that count's own register.
`timescale 1ns / 1ps
`default_nettype none

module checkpoint_reset_completion_tracker_core (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // Slave stream
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // tdata: seq_id[47:0], op_index[52:48], reset_attempt[83:53], zero pad
  input  wire logic [crt_pkg::IN_TDATA_W-1:0]  s_tdata,
  // tuser: req_type[2:0]
  input  wire logic [crt_pkg::IN_TUSER_W-1:0]  s_tuser,
  // Master stream
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // tdata: notify[1:0], proceed[2], checkpoint_epoch[50:3],
  //        reset_epoch[99:51], reset_try[130:100], region_out[146:131], pad
  output logic [crt_pkg::OUT_TDATA_W-1:0]      m_tdata,
  // Configuration write port
  input  wire logic                            cfg_we,
  input  wire logic [crt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [crt_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import crt_pkg::*;

  localparam int unsigned RES_W = $bits(crt_result_t);

  crt_cfg_t    cfg;
  crt_item_t   in_item;
  logic        in_valid;
  logic        advance;
  crt_result_t result;
  crt_result_t out_res;
  logic        out_valid;

  crt_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Move the held item into the result register whenever that register is
  // free or being drained this cycle.
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  // Input register: hold the item until the update pass consumes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.req_type      <= s_tuser;
      in_item.seq_id        <= s_tdata[SEQ_W-1:0];
      in_item.op_index      <= s_tdata[SEQ_W +: OP_W];
      in_item.reset_attempt <= s_tdata[SEQ_W+OP_W +: TRY_W];
    end
  end

  crt_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .item   (in_item),
    .cfg    (cfg),
    .result (result)
  );

  // Result register: load on advance, drop valid once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(OUT_TDATA_W - RES_W){1'b0}},
                     out_res.region_out,
                     out_res.reset_try,
                     out_res.reset_epoch,
                     out_res.checkpoint_epoch,
                     out_res.proceed,
                     out_res.notify};

endmodule

`default_nettype wire

@@ tb/tb_checkpoint_reset_completion_tracker_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_checkpoint_reset_completion_tracker_core
// Self-checking bench for the checkpoint/reset epoch completion tracker.
// ----------------------------------------------------------------------------
// A short directed walk covers reset values, epoch extremes, unknown request
// kinds, stale events, the stale blocking flag and an oversized non-blocking
// set. It is followed by random phases built mostly from complete checkpoint
// and reset rounds. Each phase uses its own register setting and handshake
// pressure. Every accepted item is run through a local model of the tracker,
// and every result on the master stream is compared field by field.
// ----------------------------------------------------------------------------

module tb_checkpoint_reset_completion_tracker_core;
  import crt_pkg::*;

  localparam int CLK_PERIOD  = 10;
  localparam int HOLD_CYCLES = 300;       // long receiver hold-off
  localparam int LIMIT_NS    = 5_000_000; // watchdog, far above the slowest run
  localparam logic [SEQ_W-1:0] SEQ_MAX = '1;
  localparam logic [TRY_W-1:0] TRY_MAX = '1;

  // --------------------------------------------------------------------------
  // Clock, reset and block ports; every input known from time zero
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_TDATA_W-1:0] s_tdata = '0;
  logic [IN_TUSER_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  checkpoint_reset_completion_tracker_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Tracker model: a copy of the registers and the epoch state
  // --------------------------------------------------------------------------
  logic [CNT_W-1:0]  cfg_nops   = 6'd1;
  logic [MASK_W-1:0] cfg_mask   = '0;
  logic [REG_W-1:0]  cfg_region = '0;

  logic             in_reset = 1'b0;
  logic             blk_flag = 1'b0;
  logic [SEQ_W-1:0] ck_epoch = '0;
  longint           rs_epoch = -1;
  logic [TRY_W-1:0] rs_try   = '0;
  logic [CNT_W-1:0] n_drain  = '0;
  logic [CNT_W-1:0] n_blk    = '0;
  logic [CNT_W-1:0] n_nonblk = '0;
  logic [CNT_W-1:0] n_reset  = '0;

  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
    return (c == {CNT_W{1'b1}}) ? c : c + 1'b1;
  endfunction

  function automatic void clear_counts();
    n_drain  = '0;
    n_blk    = '0;
    n_nonblk = '0;
    n_reset  = '0;
    blk_flag = 1'b0;
  endfunction

  // Completion test after a checkpoint-side counter moved.
  function automatic logic [1:0] ckpt_verdict();
    int nb;
    nb = $countones(cfg_mask);
    if (n_drain != cfg_nops) return NOTIFY_NONE;
    if (nb > 0) begin
      if (int'(n_blk) + int'(n_nonblk) == int'(cfg_nops)) begin
        clear_counts();
        return NOTIFY_CKPT_DONE;
      end
      // More non-blocking operators than the group holds: never blocking-complete
      if (nb <= int'(cfg_nops) && int'(n_blk) == int'(cfg_nops) - nb && !blk_flag) begin
        blk_flag = 1'b1;
        return NOTIFY_BLOCKING;
      end
      return NOTIFY_NONE;
    end
    if (n_blk != cfg_nops) return NOTIFY_NONE;
    clear_counts();
    return NOTIFY_CKPT_DONE;
  endfunction

  // Advance the model by one accepted item and return the result it owes.
  function automatic crt_result_t track_item(input crt_item_t it);
    crt_result_t r;
    logic [1:0]  note;
    logic        go;
    logic        nb;
    logic        counted;
    longint      sq;
    note    = NOTIFY_NONE;
    go      = 1'b0;
    counted = 1'b1;
    sq      = longint'(it.seq_id);
    nb      = cfg_mask[it.op_index];
    case (it.req_type)
      REQ_DRAIN_DONE: begin
        if (it.seq_id > ck_epoch) begin
          ck_epoch = it.seq_id;
          n_drain  = 6'd1;
          n_blk    = '0;
          n_nonblk = '0;
          note     = ckpt_verdict();
        end else if (it.seq_id == ck_epoch) begin
          n_drain = bump(n_drain);
          note    = ckpt_verdict();
        end
      end
      REQ_CKPT_DONE: begin
        if (it.seq_id > ck_epoch) begin
          // Newer epoch restarts counters but leaves the blocking flag alone
          ck_epoch = it.seq_id;
          n_drain  = '0;
          n_nonblk = nb ? 6'd1 : 6'd0;
          n_blk    = nb ? 6'd0 : 6'd1;
          note     = ckpt_verdict();
        end else if (it.seq_id == ck_epoch) begin
          if (nb) n_nonblk = bump(n_nonblk);
          else n_blk = bump(n_blk);
          note = ckpt_verdict();
        end
      end
      REQ_RESET_DONE: begin
        // Any reset event marks the region as resetting, stale or not
        in_reset = 1'b1;
        if (sq < rs_epoch) begin
          counted = 1'b0;
        end else if (sq > rs_epoch) begin
          rs_epoch = sq;
          rs_try   = it.reset_attempt;
          n_reset  = 6'd1;
        end else if (it.reset_attempt == rs_try) begin
          n_reset = bump(n_reset);
        end else if (it.reset_attempt > rs_try) begin
          rs_try  = it.reset_attempt;
          n_reset = 6'd1;
        end else begin
          counted = 1'b0;
        end
        if (counted && n_reset == cfg_nops) begin
          note     = NOTIFY_RESET_DONE;
          in_reset = 1'b0;
          clear_counts();
        end
      end
      REQ_CKPT_QUERY: go = !in_reset && it.seq_id >= ck_epoch;
      REQ_RESET_QUERY: go = !(sq < rs_epoch || (sq == rs_epoch && it.reset_attempt < rs_try));
      default: ; // unknown kinds leave the state untouched
    endcase
    r.notify           = note;
    r.proceed          = go;
    r.checkpoint_epoch = ck_epoch;
    r.reset_epoch      = rs_epoch[EPOCH_W-1:0];
    r.reset_try        = rs_try;
    r.region_out       = cfg_region;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Pending results, counters and the directed walk
  // --------------------------------------------------------------------------
  typedef struct packed {
    int unsigned idx;
    logic [1:0]  notify;
    logic        proceed;
  } fixed_verdict_t;

  typedef struct packed {
    logic                  is_cfg;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_val;
    crt_item_t             it;
    logic                  fixed;
    logic [1:0]            f_notify;
    logic                  f_proceed;
  } drill_row_t;

  crt_result_t    pending_results[$];
  fixed_verdict_t fixed_verdicts[$];
  drill_row_t     drill[$];
  crt_item_t      round_q[$];

  int unsigned items_accepted = 0;
  int unsigned results_seen   = 0;
  int unsigned errors         = 0;
  int unsigned n_settings     = 0;
  int unsigned n_ckpt_done    = 0;
  int unsigned n_blocking     = 0;
  int unsigned n_reset_done   = 0;

  // Handshake pressure knobs, set between phases
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  bit rx_hold      = 1'b0;
  int hold_cnt     = 0;

  function automatic crt_item_t item_of(input logic [2:0] req, input logic [SEQ_W-1:0] seq,
                                        input logic [OP_W-1:0] op,
                                        input logic [TRY_W-1:0] att);
    crt_item_t it;
    it.req_type      = req;
    it.seq_id        = seq;
    it.op_index      = op;
    it.reset_attempt = att;
    return it;
  endfunction

  function automatic drill_row_t row_ev(input logic [2:0] req, input logic [SEQ_W-1:0] seq,
                                        input logic [OP_W-1:0] op,
                                        input logic [TRY_W-1:0] att);
    drill_row_t r;
    r        = '0;
    r.it     = item_of(req, seq, op, att);
    return r;
  endfunction

  // Row whose verdict can be read straight off the spec
  function automatic drill_row_t row_fix(input logic [2:0] req, input logic [SEQ_W-1:0] seq,
                                         input logic [OP_W-1:0] op,
                                         input logic [TRY_W-1:0] att,
                                         input logic [1:0] notify, input logic proceed);
    drill_row_t r;
    r           = row_ev(req, seq, op, att);
    r.fixed     = 1'b1;
    r.f_notify  = notify;
    r.f_proceed = proceed;
    return r;
  endfunction

  function automatic drill_row_t row_cfg(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] val);
    drill_row_t r;
    r         = '0;
    r.is_cfg  = 1'b1;
    r.cfg_idx = idx;
    r.cfg_val = val;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Random item source
  // --------------------------------------------------------------------------
  // Queue a round event; drop a few and double a few to break rounds.
  function automatic void add_event(input crt_item_t ev);
    if ($urandom_range(99) >= 4) round_q.push_back(ev);
    if ($urandom_range(99) < 3) round_q.push_back(ev);
  endfunction

  // Build one full round for the group: either a checkpoint epoch (drain and
  // checkpoint from every operator) or a reset epoch/attempt, then shuffle.
  function automatic void build_round();
    crt_item_t        tmp;
    logic [SEQ_W-1:0] ep;
    logic [TRY_W-1:0] at;
    int               n;
    int               j;
    int               k;
    n = (cfg_nops == 0) ? 1 : int'(cfg_nops);
    if ($urandom_range(99) < 65) begin
      ep = (ck_epoch > SEQ_MAX - 4) ? ck_epoch : ck_epoch + SEQ_W'($urandom_range(3, 1));
      for (k = 0; k < n; k++) begin
        add_event(item_of(REQ_DRAIN_DONE, ep, OP_W'(k), TRY_W'($urandom)));
        add_event(item_of(REQ_CKPT_DONE, ep, OP_W'(k), TRY_W'($urandom)));
      end
    end else begin
      if (rs_epoch < 0 || $urandom_range(1) == 1) begin
        ep = (rs_epoch < 0) ? '0 : rs_epoch[SEQ_W-1:0] + 1'b1;
        at = TRY_W'($urandom_range(5));
      end else begin
        ep = rs_epoch[SEQ_W-1:0];
        at = rs_try + 1'b1;
      end
      for (k = 0; k < n; k++) add_event(item_of(REQ_RESET_DONE, ep, OP_W'(k), at));
    end
    for (k = round_q.size() - 1; k > 0; k--) begin
      j          = $urandom_range(k);
      tmp        = round_q[k];
      round_q[k] = round_q[j];
      round_q[j] = tmp;
    end
  endfunction

  // Mostly round events, then queries around the live epochs, then noise.
  function automatic crt_item_t next_item();
    crt_item_t        it;
    logic [63:0]      wide;
    logic [SEQ_W-1:0] base;
    int               pick;
    pick = $urandom_range(99);
    wide = {$urandom, $urandom};
    if (pick < 62) begin
      if (round_q.size() == 0) build_round();
      it = round_q.pop_front();
    end else if (pick < 84) begin
      base = ($urandom_range(1) == 1) ? ck_epoch : rs_epoch[SEQ_W-1:0];
      it = item_of(($urandom_range(1) == 1) ? REQ_CKPT_QUERY : REQ_RESET_QUERY,
                   base + SEQ_W'($urandom_range(2)) - 1'b1, OP_W'($urandom),
                   rs_try + TRY_W'($urandom_range(2)) - 1'b1);
    end else begin
      base = ($urandom_range(1) == 1) ? wide[SEQ_W-1:0]
                                      : ck_epoch - SEQ_W'($urandom_range(3));
      it = item_of(3'($urandom_range(7)), base, OP_W'($urandom), TRY_W'($urandom));
    end
    return it;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus side
  // --------------------------------------------------------------------------
  // Offer one item and hold it until taken; then maybe idle for a while.
  task automatic send_item(input crt_item_t it);
    s_tuser  <= it.req_type;
    s_tdata  <= {4'b0, it.reset_attempt, it.op_index, it.seq_id};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    items_accepted++;
    if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
  endtask

  // Drop valid and wait until every result is back and the pipe is quiet.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (results_seen < items_accepted) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_NUM_OPERATORS:    cfg_nops   = val[CNT_W-1:0];
      CFG_NONBLOCKING_MASK: cfg_mask   = val[MASK_W-1:0];
      CFG_REGION_INDEX:     cfg_region = val[REG_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // One random phase: new setting, new pressure, then a run of items.
  // A flood phase piles events on one epoch to push the counters to saturation.
  task automatic run_phase(input int tx_pct, input int rx_pct, input bit hold,
                           input logic [CNT_W-1:0] nops, input logic [MASK_W-1:0] mask,
                           input logic [REG_W-1:0] region, input int count, input bit flood);
    crt_item_t        it;
    logic [SEQ_W-1:0] ep;
    int               k;
    settle();
    write_cfg(CFG_NUM_OPERATORS, CFG_DATA_W'(nops));
    write_cfg(CFG_NONBLOCKING_MASK, CFG_DATA_W'(mask));
    write_cfg(CFG_REGION_INDEX, CFG_DATA_W'(region));
    n_settings++;
    repeat (3) @(posedge clk); // let the registered non-blocking count settle
    round_q.delete();
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    rx_hold      = hold;
    ep = (ck_epoch == SEQ_MAX) ? ck_epoch : ck_epoch + 1'b1;
    for (k = 0; k < count; k++) begin
      if (flood)
        it = item_of((k < count - 4) ? REQ_DRAIN_DONE : REQ_CKPT_DONE, ep,
                     OP_W'($urandom), TRY_W'($urandom));
      else
        it = next_item();
      send_item(it);
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off counted here
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (rx_hold && hold_cnt < HOLD_CYCLES) begin
      m_tready <= 1'b0;
      hold_cnt <= hold_cnt + 1;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Input monitor: predict at the accepting edge
  // --------------------------------------------------------------------------
  crt_item_t seen_item;

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      seen_item.req_type      = s_tuser;
      seen_item.seq_id        = s_tdata[47:0];
      seen_item.op_index      = s_tdata[52:48];
      seen_item.reset_attempt = s_tdata[83:53];
      pending_results.push_back(track_item(seen_item));
    end
  end

  // --------------------------------------------------------------------------
  // Result checker
  // --------------------------------------------------------------------------
  crt_result_t got_r;
  crt_result_t want_r;

  function automatic void check_field(input string fld, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", fld, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_r.notify           = m_tdata[1:0];
      got_r.proceed          = m_tdata[2];
      got_r.checkpoint_epoch = m_tdata[50:3];
      got_r.reset_epoch      = m_tdata[99:51];
      got_r.reset_try        = m_tdata[130:100];
      got_r.region_out       = m_tdata[146:131];
      if (pending_results.size() == 0) begin
        $error("result %0d arrived with nothing pending", results_seen);
        errors++;
      end else begin
        want_r = pending_results.pop_front();
        check_field("notify", want_r.notify, got_r.notify);
        check_field("proceed", want_r.proceed, got_r.proceed);
        check_field("checkpoint_epoch", want_r.checkpoint_epoch, got_r.checkpoint_epoch);
        check_field("reset_epoch", want_r.reset_epoch, got_r.reset_epoch);
        check_field("reset_try", want_r.reset_try, got_r.reset_try);
        check_field("region_out", want_r.region_out, got_r.region_out);
      end
      // Directed rows with a hand-written verdict get it checked as well
      if (fixed_verdicts.size() != 0 && fixed_verdicts[0].idx == results_seen) begin
        check_field("notify (fixed)", fixed_verdicts[0].notify, got_r.notify);
        check_field("proceed (fixed)", fixed_verdicts[0].proceed, got_r.proceed);
        void'(fixed_verdicts.pop_front());
      end
      case (got_r.notify)
        NOTIFY_BLOCKING:   n_blocking++;
        NOTIFY_CKPT_DONE:  n_ckpt_done++;
        NOTIFY_RESET_DONE: n_reset_done++;
        default: ;
      endcase
      results_seen++;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    fixed_verdict_t fv;
    // Reset-time registers: one operator, no non-blocking set, region 0
    drill.push_back(row_fix(REQ_CKPT_QUERY, '0, '0, '0, NOTIFY_NONE, 1'b1));
    drill.push_back(row_fix(REQ_RESET_QUERY, '0, '0, '0, NOTIFY_NONE, 1'b1));
    drill.push_back(row_fix(3'd7, SEQ_MAX, 5'd31, TRY_MAX, NOTIFY_NONE, 1'b0));
    drill.push_back(row_fix(3'd5, '0, '0, '0, NOTIFY_NONE, 1'b0));
    drill.push_back(row_ev(REQ_DRAIN_DONE, 48'd5, '0, '0));
    drill.push_back(row_fix(REQ_CKPT_DONE, 48'd5, '0, '0, NOTIFY_CKPT_DONE, 1'b0));
    drill.push_back(row_ev(REQ_CKPT_DONE, 48'd3, '0, '0));        // older epoch
    drill.push_back(row_fix(REQ_RESET_DONE, '0, '0, 31'd7, NOTIFY_RESET_DONE, 1'b0));
    drill.push_back(row_ev(REQ_RESET_DONE, '0, '0, 31'd2));       // older attempt
    drill.push_back(row_fix(REQ_CKPT_QUERY, SEQ_MAX, '0, '0, NOTIFY_NONE, 1'b0));
    drill.push_back(row_fix(REQ_RESET_QUERY, '0, '0, 31'd1, NOTIFY_NONE, 1'b0));
    drill.push_back(row_fix(REQ_RESET_DONE, 48'd1, '0, '0, NOTIFY_RESET_DONE, 1'b0));
    // Three operators, operators 1 and 2 non-blocking
    drill.push_back(row_cfg(CFG_NUM_OPERATORS, 32'd3));
    drill.push_back(row_cfg(CFG_NONBLOCKING_MASK, 32'h6));
    drill.push_back(row_cfg(CFG_REGION_INDEX, 32'hFFFF));
    drill.push_back(row_ev(REQ_DRAIN_DONE, 48'd6, '0, '0));
    drill.push_back(row_ev(REQ_DRAIN_DONE, 48'd6, '0, '0));
    drill.push_back(row_ev(REQ_DRAIN_DONE, 48'd6, '0, '0));
    drill.push_back(row_fix(REQ_CKPT_DONE, 48'd6, 5'd0, '0, NOTIFY_BLOCKING, 1'b0));
    drill.push_back(row_ev(REQ_CKPT_DONE, 48'd6, 5'd1, '0));
    // New epoch keeps the blocking flag, so no second blocking notice
    drill.push_back(row_ev(REQ_DRAIN_DONE, 48'd7, '0, '0));
    drill.push_back(row_ev(REQ_DRAIN_DONE, 48'd7, '0, '0));
    drill.push_back(row_ev(REQ_DRAIN_DONE, 48'd7, '0, '0));
    drill.push_back(row_fix(REQ_CKPT_DONE, 48'd7, 5'd0, '0, NOTIFY_NONE, 1'b0));
    drill.push_back(row_ev(REQ_CKPT_DONE, 48'd7, 5'd1, '0));
    drill.push_back(row_fix(REQ_CKPT_DONE, 48'd7, 5'd2, '0, NOTIFY_CKPT_DONE, 1'b0));
    // One operator against a full non-blocking mask
    drill.push_back(row_cfg(CFG_NUM_OPERATORS, 32'd1));
    drill.push_back(row_cfg(CFG_NONBLOCKING_MASK, 32'hFFFF_FFFF));
    drill.push_back(row_ev(REQ_DRAIN_DONE, SEQ_MAX, '0, '0));
    drill.push_back(row_fix(REQ_CKPT_DONE, SEQ_MAX, 5'd31, '0, NOTIFY_CKPT_DONE, 1'b0));
    drill.push_back(row_fix(REQ_RESET_DONE, SEQ_MAX, '0, TRY_MAX, NOTIFY_RESET_DONE, 1'b0));

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed rows with no idling on either side
    foreach (drill[i]) begin
      if (drill[i].is_cfg) begin
        settle();
        write_cfg(drill[i].cfg_idx, drill[i].cfg_val);
        n_settings++;
        repeat (3) @(posedge clk);
      end else begin
        if (drill[i].fixed) begin
          fv.idx     = items_accepted;
          fv.notify  = drill[i].f_notify;
          fv.proceed = drill[i].f_proceed;
          fixed_verdicts.push_back(fv);
        end
        send_item(drill[i].it);
      end
    end

    // Random phases: tx idle %, rx stall %, hold-off, operators, mask, region
    run_phase(0, 0, 1'b0, 6'd32, MASK_W'($urandom), REG_W'($urandom), 100, 1'b0);
    run_phase(77, 0, 1'b0, 6'd1, '0, '0, 80, 1'b0);
    run_phase(0, 77, 1'b0, 6'd4, MASK_W'($urandom_range(15)), 16'hFFFF, 80, 1'b0);
    run_phase(30, 30, 1'b0, 6'($urandom_range(6, 2)), MASK_W'($urandom) & 32'h3F,
              REG_W'($urandom), 80, 1'b0);
    // Receiver holds off while the sender keeps pushing: the block must back up
    run_phase(0, 0, 1'b1, 6'd3, '1, REG_W'($urandom), 40, 1'b0);
    run_phase(0, 30, 1'b0, 6'd32, '0, REG_W'($urandom), 70, 1'b1);

    settle();
    repeat (6) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      errors++;
    end

    $display("Covered %0d items over %0d register settings with idle, stall and hold-off.",
             items_accepted, n_settings);
    $display("Seen %0d checkpoint, %0d blocking and %0d reset completions; %0d errors.",
             n_ckpt_done, n_blocking, n_reset_done, errors);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(LIMIT_NS);
    $display("Timed out: %0d items accepted, %0d results seen.", items_accepted, results_seen);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
